// ----- sv/nucleotide_entropy_gc_stats_macros.svh -----
// Assertion macros shared by the nucleotide statistics modules.
// No dependencies; included by the controller and the datapath.
`ifndef NUCLEOTIDE_ENTROPY_GC_STATS_MACROS_SVH
`define NUCLEOTIDE_ENTROPY_GC_STATS_MACROS_SVH

// Check that a property holds at every clock edge while reset is low.
`define NUC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check that an expression holds at every clock edge, also during reset.
`define NUC_ASSERT_ALWAYS(label, clk, expr) \
   label: assert property (@(posedge clk) expr) \
      else $error("assertion failed");

`endif

// ----- sv/nuc_gc_pkg.sv -----
// Shared types and constants for the nucleotide entropy and GC statistics block.
// No dependencies; used by nuc_gc_ctrl, nuc_gc_dp and the top level.
package nuc_gc_pkg;

   localparam int unsigned CNT_W   = 21;
   localparam int unsigned LOG_W   = 37;
   localparam int unsigned MANT_W  = 32;
   localparam int unsigned SUM_W   = 60;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned ENT_W   = 18;
   localparam int unsigned GC_W    = 17;
   localparam int unsigned MSB_W   = 5;
   localparam int unsigned D_LO_W  = 19;

   localparam logic [CNT_W-1:0]  MAX_LEN    = 21'd1048576;
   localparam logic [STEP_W-1:0] LOG_STEPS  = 6'd31;
   localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd59;

   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [3:0] {
      S_COUNT,
      S_CHECK,
      S_LOG_LEN,
      S_LEN_SAVE,
      S_BASE,
      S_LOG_C,
      S_MUL_LO,
      S_MUL_HI,
      S_DIV_ENT_LOAD,
      S_DIV_ENT,
      S_DIV_GC_LOAD,
      S_DIV_GC,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic count;
      logic snap;
      logic log_load;
      logic log_sel_len;
      logic log_step;
      logic lglen_save;
      logic idx_clear;
      logic idx_next;
      logic mul_lo;
      logic mul_hi;
      logic div_load;
      logic div_sel_gc;
      logic div_step;
      logic ent_save;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bases_zero;
      logic cnt_zero;
      logic idx_last;
      logic step_done;
      logic rsp_busy;
   } status_type;

endpackage

// ----- sv/nuc_gc_ctrl.sv -----
// Sequencer for the nucleotide statistics block: counting, log, multiply, divide.
// Depends on nuc_gc_pkg and nucleotide_entropy_gc_stats_macros.svh.
`include "nucleotide_entropy_gc_stats_macros.svh"

module nuc_gc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_char,
   output logic                   req_ready,
   input  nuc_gc_pkg::status_type status,
   output nuc_gc_pkg::cmd_type    cmd
);

   nuc_gc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nuc_gc_pkg::S_COUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         nuc_gc_pkg::S_COUNT: begin
            req_ready = 1'b1;
            cmd.count = req_valid;
            if (req_valid && req_last_char) begin
               cmd.snap = 1'b1;
               state_in = nuc_gc_pkg::S_CHECK;
            end
         end
         nuc_gc_pkg::S_CHECK: begin
            cmd.idx_clear = 1'b1;
            if (status.bases_zero) begin
               state_in = nuc_gc_pkg::S_FINISH;
            end else begin
               cmd.log_load    = 1'b1;
               cmd.log_sel_len = 1'b1;
               state_in        = nuc_gc_pkg::S_LOG_LEN;
            end
         end
         nuc_gc_pkg::S_LOG_LEN: begin
            cmd.log_step = 1'b1;
            if (status.step_done) state_in = nuc_gc_pkg::S_LEN_SAVE;
         end
         nuc_gc_pkg::S_LEN_SAVE: begin
            cmd.lglen_save = 1'b1;
            state_in       = nuc_gc_pkg::S_BASE;
         end
         nuc_gc_pkg::S_BASE: begin
            if (!status.cnt_zero) begin
               cmd.log_load = 1'b1;
               state_in     = nuc_gc_pkg::S_LOG_C;
            end else if (status.idx_last) begin
               state_in = nuc_gc_pkg::S_DIV_ENT_LOAD;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         nuc_gc_pkg::S_LOG_C: begin
            cmd.log_step = 1'b1;
            if (status.step_done) state_in = nuc_gc_pkg::S_MUL_LO;
         end
         nuc_gc_pkg::S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = nuc_gc_pkg::S_MUL_HI;
         end
         nuc_gc_pkg::S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            if (status.idx_last) begin
               state_in = nuc_gc_pkg::S_DIV_ENT_LOAD;
            end else begin
               cmd.idx_next = 1'b1;
               state_in     = nuc_gc_pkg::S_BASE;
            end
         end
         nuc_gc_pkg::S_DIV_ENT_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = nuc_gc_pkg::S_DIV_ENT;
         end
         nuc_gc_pkg::S_DIV_ENT: begin
            cmd.div_step = 1'b1;
            if (status.step_done) state_in = nuc_gc_pkg::S_DIV_GC_LOAD;
         end
         nuc_gc_pkg::S_DIV_GC_LOAD: begin
            cmd.ent_save   = 1'b1;
            cmd.div_load   = 1'b1;
            cmd.div_sel_gc = 1'b1;
            state_in       = nuc_gc_pkg::S_DIV_GC;
         end
         nuc_gc_pkg::S_DIV_GC: begin
            cmd.div_step = 1'b1;
            if (status.step_done) state_in = nuc_gc_pkg::S_FINISH;
         end
         nuc_gc_pkg::S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = nuc_gc_pkg::S_COUNT;
            end
         end
         default: begin
            state_in = nuc_gc_pkg::S_COUNT;
         end
      endcase
   end

   `NUC_ASSERT_IMPL(a_snap_starts_calc, clock, reset,
      cmd.snap |=> state_ff == nuc_gc_pkg::S_CHECK)
   `NUC_ASSERT_IMPL(a_load_returns_to_count, clock, reset,
      cmd.out_load |=> req_ready)

endmodule

// ----- sv/nuc_gc_dp.sv -----
// Datapath: character counters, log2 by repeated squaring, multiply-accumulate,
// restoring divider and result registers. Depends on nuc_gc_pkg and the macros.
`include "nucleotide_entropy_gc_stats_macros.svh"

module nuc_gc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  nuc_gc_pkg::cmd_type    cmd,
   output nuc_gc_pkg::status_type status,
   input  logic [7:0]             req_char_code,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [17:0]            rsp_entropy_q16,
   output logic [16:0]            rsp_gc_fraction_q16,
   output logic [20:0]            rsp_base_total,
   output logic [20:0]            rsp_char_total,
   output logic                   rsp_count_overflow
);

   localparam int unsigned CW = nuc_gc_pkg::CNT_W;
   localparam int unsigned LW = nuc_gc_pkg::LOG_W;
   localparam int unsigned MW = nuc_gc_pkg::MANT_W;
   localparam int unsigned SW = nuc_gc_pkg::SUM_W;
   localparam int unsigned TW = nuc_gc_pkg::STEP_W;
   localparam int unsigned DL = nuc_gc_pkg::D_LO_W;

   // running counters
   logic [CW-1:0] cnt_ff [4];
   logic [CW-1:0] cnt_in [4];
   logic [CW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   // snapshot of a finished sequence
   logic [CW-1:0] wc_ff [4];
   logic [CW-1:0] wlen_ff;
   logic [CW-1:0] wbases_ff;
   logic          wovf_ff;
   // arithmetic
   logic [MW-1:0] y_ff, y_in;
   logic [LW-1:0] r_ff, r_in;
   logic [LW-1:0] lglen_ff;
   logic [SW-1:0] sum_ff, sum_in;
   logic [SW-1:0] dv_ff, dv_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] dvs_ff, dvs_in;
   logic [TW-1:0] step_ff, step_in;
   logic [1:0]    idx_ff;
   logic [17:0]   ent_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [7:0]    ch_up;
   logic [3:0]    hit;
   logic          at_max;
   logic [CW-1:0] cnt_nx [4];
   logic [CW-1:0] len_nx;
   logic          ovf_nx;
   logic [CW-1:0] bases_nx;
   logic [CW-1:0] log_x;
   logic [4:0]    msb;
   logic [MW-1:0] y_init;
   logic [63:0]   sq;
   logic [MW:0]   sq_sh;
   logic [LW-1:0] dlog;
   logic [SW-1:0] prod;
   logic [CW:0]   rem_sh;
   logic [CW:0]   rem_sub;
   logic [CW-1:0] gc_sum;
   logic [36:0]   gc_dividend;
   logic [SW:0]   ent_round;

   // fold case, classify, update counters with saturation
   always_comb begin
      ch_up = req_char_code;
      if (req_char_code >= nuc_gc_pkg::CHAR_LOWER_A &&
          req_char_code <= nuc_gc_pkg::CHAR_LOWER_Z) begin
         ch_up = req_char_code - nuc_gc_pkg::CASE_OFFSET;
      end
      hit[0] = ch_up == nuc_gc_pkg::CHAR_A;
      hit[1] = ch_up == nuc_gc_pkg::CHAR_C;
      hit[2] = ch_up == nuc_gc_pkg::CHAR_G;
      hit[3] = ch_up == nuc_gc_pkg::CHAR_T;
      at_max = len_ff == nuc_gc_pkg::MAX_LEN;
      ovf_nx = ovf_ff | at_max;
      len_nx = at_max ? len_ff : len_ff + CW'(1);
      for (int i = 0; i < 4; i++) begin
         cnt_nx[i] = (!at_max && hit[i]) ? cnt_ff[i] + CW'(1) : cnt_ff[i];
      end
      bases_nx = cnt_nx[0] + cnt_nx[1] + cnt_nx[2] + cnt_nx[3];
      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (cmd.snap) begin
         for (int i = 0; i < 4; i++) begin
            cnt_in[i] = '0;
         end
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.count) begin
         for (int i = 0; i < 4; i++) begin
            cnt_in[i] = cnt_nx[i];
         end
         len_in = len_nx;
         ovf_in = ovf_nx;
      end
   end

   // log2 setup, squaring step, multiply-accumulate, divider step
   always_comb begin
      log_x = cmd.log_sel_len ? wlen_ff : wc_ff[idx_ff];
      msb   = '0;
      for (int i = 0; i < CW; i++) begin
         if (log_x[i]) msb = 5'(i);
      end
      y_init = {11'b0, log_x} << (5'd31 - msb);
      sq     = 64'(y_ff) * 64'(y_ff);
      sq_sh  = sq[63:31];
      dlog   = (lglen_ff > r_ff) ? lglen_ff - r_ff : '0;
      prod   = '0;
      if (cmd.mul_lo) begin
         prod = SW'(wc_ff[idx_ff]) * SW'(dlog[DL-1:0]);
      end else begin
         prod = (SW'(wc_ff[idx_ff]) * SW'(dlog[LW-1:DL])) << DL;
      end
      rem_sh  = {rem_ff, dv_ff[SW-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      gc_sum      = wc_ff[1] + wc_ff[2];
      gc_dividend = {gc_sum[20:0], 16'b0} + 37'(wbases_ff >> 1);
      ent_round   = {1'b0, dv_ff} + (SW+1)'(32768);

      y_in    = y_ff;
      r_in    = r_ff;
      sum_in  = sum_ff;
      dv_in   = dv_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      if (cmd.log_load) begin
         y_in    = y_init;
         r_in    = {msb, 32'b0};
         step_in = nuc_gc_pkg::LOG_STEPS;
      end else if (cmd.log_step) begin
         if (sq_sh[MW]) begin
            y_in = sq_sh[MW:1];
            r_in = r_ff | (LW'(1) << step_ff[4:0]);
         end else begin
            y_in = sq_sh[MW-1:0];
         end
         step_in = step_ff - TW'(1);
      end
      if (cmd.idx_clear) begin
         sum_in = '0;
      end else if (cmd.mul_lo || cmd.mul_hi) begin
         sum_in = sum_ff + prod;
      end
      if (cmd.div_load) begin
         dv_in   = cmd.div_sel_gc ? SW'(gc_dividend) : sum_ff;
         dvs_in  = cmd.div_sel_gc ? wbases_ff : wlen_ff;
         rem_in  = '0;
         step_in = nuc_gc_pkg::DIV_STEPS;
      end else if (cmd.div_step) begin
         if (!rem_sub[CW]) begin
            rem_in = rem_sub[CW-1:0];
            dv_in  = {dv_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CW-1:0];
            dv_in  = {dv_ff[SW-2:0], 1'b0};
         end
         step_in = step_ff - TW'(1);
      end
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         for (int i = 0; i < 4; i++) begin
            wc_ff[i] <= cnt_nx[i];
         end
         wlen_ff   <= len_nx;
         wovf_ff   <= ovf_nx;
         wbases_ff <= bases_nx;
      end
      y_ff    <= y_in;
      r_ff    <= r_in;
      sum_ff  <= sum_in;
      dv_ff   <= dv_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (cmd.lglen_save) lglen_ff <= r_ff;
      if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_next) begin
         idx_ff <= idx_ff + 2'd1;
      end
      if (cmd.ent_save) ent_ff <= ent_round[33:16];
      if (cmd.out_load) begin
         rsp_entropy_q16     <= (wbases_ff == '0) ? '0 : ent_ff;
         rsp_gc_fraction_q16 <= (wbases_ff == '0) ? '0 : dv_ff[16:0];
         rsp_base_total      <= wbases_ff;
         rsp_char_total      <= wlen_ff;
         rsp_count_overflow  <= wovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign status.bases_zero = wbases_ff == '0;
   assign status.cnt_zero   = wc_ff[idx_ff] == '0;
   assign status.idx_last   = idx_ff == 2'd3;
   assign status.step_done  = step_ff == '0;
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_ready;

   `NUC_ASSERT_IMPL(a_len_bounded, clock, reset, len_ff <= nuc_gc_pkg::MAX_LEN)
   `NUC_ASSERT_IMPL(a_load_when_free, clock, reset,
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
   `NUC_ASSERT_IMPL(a_snap_clears, clock, reset,
      cmd.snap |=> len_ff == '0 && !ovf_ff)

endmodule

// ----- sv/nucleotide_entropy_gc_stats.sv -----
// Top level of the nucleotide entropy and GC statistics block.
// Depends on nuc_gc_pkg, nuc_gc_ctrl and nuc_gc_dp.
//
// Usage:
//   Input channel req_*: one ASCII character per item, req_last_char marks
//   the end of a sequence. Lower-case letters count as upper case; anything
//   other than A, C, G, T counts in the length only.
//   Result channel rsp_*: one item per sequence, issued after its last
//   character: entropy (2.16), GC fraction (1.16), base and character totals,
//   and a flag set when the length saturated at MAX_LEN.
//   Throughput: characters are counted at one per cycle. After the last
//   character the block stops taking items while the sequencer runs: a log2
//   by repeated squaring for the length and every nonzero base, a
//   multiply-accumulate over the low and high halves per nonzero base and
//   two restoring divisions; when the sequence held no bases, all of this
//   is skipped.
//   The result register frees the input side: the next sequence is counted
//   while a result waits; the next result and the input wait for rsp_ready.
//   Reset (synchronous) clears the counters and drops any pending result.
module nucleotide_entropy_gc_stats (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [17:0] rsp_entropy_q16,
   output logic [16:0] rsp_gc_fraction_q16,
   output logic [20:0] rsp_base_total,
   output logic [20:0] rsp_char_total,
   output logic        rsp_count_overflow
);

   nuc_gc_pkg::cmd_type    cmd;
   nuc_gc_pkg::status_type status;

   // sequencer: decides what the datapath does each cycle
   nuc_gc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_char (req_last_char),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // counters, log unit, accumulator, divider and result register
   nuc_gc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_char_code       (req_char_code),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_entropy_q16     (rsp_entropy_q16),
      .rsp_gc_fraction_q16 (rsp_gc_fraction_q16),
      .rsp_base_total      (rsp_base_total),
      .rsp_char_total      (rsp_char_total),
      .rsp_count_overflow  (rsp_count_overflow)
   );

endmodule
